// ----- rtl/att_pkg.sv -----
// Shared types, constants and helpers for the scrollback text terminal.
// Used by att_ram, att_core and ansi_text_terminal_scrollback.
package att_pkg;

  // Default sizes handed down from the top level.
  localparam int unsigned DEF_MAX_COLS         = 128;
  localparam int unsigned DEF_MAX_ROWS         = 64;
  localparam int unsigned DEF_SCROLLBACK_LINES = 256;
  localparam int unsigned DEF_PARAM_BYTES      = 31;

  // Cell store word: reverse bit over the character.
  localparam int unsigned CELL_W = 9;

  // Escape parameter numbers saturate here.
  localparam int unsigned   NUM_W   = 16;
  localparam logic [15:0]   NUM_MAX = 16'hFFFF;

  // Register reset values.
  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET = 7'd24;

  // Byte codes.
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] FIN_LO   = 8'h40;
  localparam logic [7:0] FIN_HI   = 8'h7E;
  localparam logic [7:0] FIN_A    = 8'h41;
  localparam logic [7:0] FIN_B    = 8'h42;
  localparam logic [7:0] FIN_C    = 8'h43;
  localparam logic [7:0] FIN_D    = 8'h44;
  localparam logic [7:0] FIN_H    = 8'h48;
  localparam logic [7:0] FIN_J    = 8'h4A;
  localparam logic [7:0] FIN_K    = 8'h4B;
  localparam logic [7:0] FIN_F    = 8'h66;
  localparam logic [7:0] FIN_M    = 8'h6D;

  // Item functions.
  typedef enum logic [1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_SCROLL = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  // Escape parser state.
  typedef enum logic [1:0] {
    ESC_TEXT = 2'd0,
    ESC_SEEN = 2'd1,
    ESC_CSI  = 2'd2
  } esc_e;

  // Register indexes (word address).
  typedef enum logic {
    REG_COLUMN_COUNT = 1'b0,
    REG_ROW_COUNT    = 1'b1
  } reg_e;

  // One input item.
  typedef struct packed {
    logic [1:0] func;
    logic [6:0] read_col;
    logic [5:0] read_row;
    logic [9:0] scroll_delta;
    logic [7:0] char_code;
  } att_item_t;

  // One result item, laid out as the output beat, listed from the top bit down.
  typedef struct packed {
    logic [8:0] lines_held;
    logic [7:0] view_offset;
    logic       cursor_visible;
    logic [6:0] cursor_column;
    logic [5:0] cursor_view_row;
    logic       cell_attr;
    logic [7:0] cell_char;
  } att_result_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

endpackage

// ----- rtl/att_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on att_pkg for default sizes.
module att_ram import att_pkg::*; #(
  parameter int unsigned WIDTH = CELL_W,
  parameter int unsigned DEPTH = DEF_SCROLLBACK_LINES * DEF_MAX_COLS,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/att_core.sv -----
// Terminal sequencer: cursor, escape parser, line ring and cell store access.
// Depends on att_pkg and att_ram.
module att_core import att_pkg::*; #(
  parameter int unsigned MAX_COLS         = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS         = DEF_MAX_ROWS,
  parameter int unsigned SCROLLBACK_LINES = DEF_SCROLLBACK_LINES,
  parameter int unsigned PARAM_BYTES      = DEF_PARAM_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  cols_cfg_i,
  input  logic [6:0]  rows_cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  att_item_t   item_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output att_result_t res_o
);

  localparam int unsigned S         = SCROLLBACK_LINES;
  localparam int unsigned ROW_LIMIT = (MAX_ROWS < S) ? MAX_ROWS : S;
  localparam int unsigned CIW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CNW       = $clog2(MAX_COLS + 1);
  localparam int unsigned PW        = $clog2(S);
  localparam int unsigned LW        = $clog2(S + 1);
  localparam int unsigned RW        = $clog2(ROW_LIMIT + 1);
  localparam int unsigned AW        = $clog2(S * MAX_COLS);
  localparam int unsigned PBI       = $clog2(PARAM_BYTES);
  localparam int unsigned PBW       = $clog2(PARAM_BYTES + 1);
  localparam int unsigned SW        = LW + NUM_W + 2;

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_PRE    = 20'h00002,
    ST_BYTE   = 20'h00004,
    ST_SCROLL = 20'h00008,
    ST_NL     = 20'h00010,
    ST_WIN    = 20'h00020,
    ST_BS     = 20'h00040,
    ST_BSW    = 20'h00080,
    ST_GROW   = 20'h00100,
    ST_PUT    = 20'h00200,
    ST_SWEEP  = 20'h00400,
    ST_ADV    = 20'h00800,
    ST_SCAN   = 20'h01000,
    ST_CSI    = 20'h02000,
    ST_NUM    = 20'h04000,
    ST_SKIP   = 20'h08000,
    ST_APPLY  = 20'h10000,
    ST_FIN    = 20'h20000,
    ST_RDA    = 20'h40000,
    ST_OUT    = 20'h80000
  } att_state_e;

  typedef enum logic [1:0] {
    PH_ROW = 2'd0,
    PH_COL = 2'd1,
    PH_CNT = 2'd2
  } att_phase_e;

  att_state_e        state_q, state_d;
  logic [PW-1:0]     ring_q, ring_d;
  logic [LW-1:0]     held_q, held_d;
  logic [PW-1:0]     vb_q, vb_d;
  logic [PW-1:0]     cl_q, cl_d;
  logic [CIW-1:0]    col_q, col_d;
  esc_e              esc_q, esc_d;
  logic [PBW-1:0]    plen_q, plen_d;
  logic              attr_q, attr_d;
  logic [S-1:0]      valid_q, valid_d;
  logic              lf_q, lf_d;
  logic              sw_put_q, sw_put_d;
  logic              rd_blank_q, rd_blank_d;
  att_phase_e        phase_q, phase_d;

  // Payload registers.
  logic [7:0]        pbuf_q [PARAM_BYTES];
  att_item_t         item_q, item_d;
  logic [PBW-1:0]    pos_q, pos_d;
  logic [PBW-1:0]    peff_q, peff_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [NUM_W-1:0]  r_q, r_d;
  logic [NUM_W-1:0]  c_q, c_d;
  logic [CNW-1:0]    k_q, k_d;
  logic              pb_we;

  // Cell store port signals.
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [CELL_W-1:0] rdata;

  // Common values.
  logic [CNW-1:0]    cols;
  logic [RW-1:0]     rows;
  logic [PW-1:0]     bf;
  logic [PW-1:0]     cur_phys;
  logic [7:0]        pb_byte;
  logic [7:0]        first_b;
  logic [7:0]        ch;
  logic [LW-1:0]     held_app;
  logic              do_append;

  // Work values of the sequencer.
  logic [LW-1:0]        nl_t, nl_h;
  logic signed [SW-1:0] cl_s, bf_s, n_s, vis_s, rows_s, vb_s;
  logic [NUM_W-1:0]     rr, cc, nn;
  logic [NUM_W:0]       csum;
  logic [19:0]          prod;
  logic [LW:0]          sr;
  logic [PW-1:0]        sr_phys;
  logic [CNW-1:0]       k_end;
  logic [CNW-1:0]       col_inc;

  function automatic logic [PW-1:0] phys_of(logic [PW-1:0] ring, logic [LW:0] logical);
    logic [LW+1:0] s;
    s = (LW+2)'(ring) + (LW+2)'(logical);
    if (s >= (LW+2)'(S)) begin
      s = s - (LW+2)'(S);
    end
    return PW'(s);
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [PW-1:0] p, logic [CIW-1:0] c);
    return AW'(p) * AW'(MAX_COLS) + AW'(c);
  endfunction

  // Register values in use, clamped to the supported ranges.
  always_comb begin
    if (cols_cfg_i == 8'd0) begin
      cols = CNW'(1);
    end else if ({1'b0, cols_cfg_i} > 9'(MAX_COLS)) begin
      cols = CNW'(MAX_COLS);
    end else begin
      cols = CNW'(cols_cfg_i);
    end
    if (rows_cfg_i == 7'd0) begin
      rows = RW'(1);
    end else if ({2'b0, rows_cfg_i} > 9'(ROW_LIMIT)) begin
      rows = RW'(ROW_LIMIT);
    end else begin
      rows = RW'(rows_cfg_i);
    end
  end

  // First line of the bottom window and other shared lookups.
  assign bf       = (held_q > LW'(rows)) ? PW'(held_q - LW'(rows)) : '0;
  assign cur_phys = phys_of(ring_q, (LW+1)'(cl_q));
  assign pb_byte  = pbuf_q[pos_q[PBI-1:0]];
  assign first_b  = (peff_q != '0) ? pbuf_q[0] : 8'd0;
  assign ch       = item_q.char_code;
  assign held_app = (held_q < LW'(S)) ? held_q + 1'b1 : held_q;

  // Signed copies for window arithmetic.
  assign cl_s   = $signed(SW'(cl_q));
  assign bf_s   = $signed(SW'(bf));
  assign vb_s   = $signed(SW'(vb_q));
  assign rows_s = $signed(SW'(rows));

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    ring_d     = ring_q;
    held_d     = held_q;
    vb_d       = vb_q;
    cl_d       = cl_q;
    col_d      = col_q;
    esc_d      = esc_q;
    plen_d     = plen_q;
    attr_d     = attr_q;
    valid_d    = valid_q;
    lf_d       = lf_q;
    sw_put_d   = sw_put_q;
    rd_blank_d = rd_blank_q;
    phase_d    = phase_q;
    item_d     = item_q;
    pos_d      = pos_q;
    peff_d     = peff_q;
    num_d      = num_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    pb_we      = 1'b0;
    do_append  = 1'b0;
    we         = 1'b0;
    waddr      = addr_of(cur_phys, col_q);
    wdata      = {1'b0, CH_SPACE};
    re         = 1'b0;
    raddr      = '0;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;
    nl_t       = LW'(cl_q) + 1'b1;
    nl_h       = (nl_t >= held_q) ? held_app : held_q;
    vis_s      = '0;
    n_s        = '0;
    rr         = r_q;
    cc         = c_q;
    nn         = r_q;
    csum       = '0;
    prod       = 20'((num_q << 3)) + 20'((num_q << 1)) + 20'(pb_byte - CH_0);
    sr         = (LW+1)'(bf) - (LW+1)'(vb_q) + (LW+1)'(item_q.read_row);
    sr_phys    = phys_of(ring_q, sr);
    k_end      = sw_put_q ? CNW'(MAX_COLS - 1) : cols - 1'b1;
    col_inc    = CNW'(col_q) + 1'b1;
    res_o      = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = item_i;
          state_d = ST_PRE;
        end
      end

      // Clamp the cursor column and view offset, then dispatch.
      ST_PRE: begin
        if (CNW'(col_q) >= cols) begin
          col_d = CIW'(cols - 1'b1);
        end
        if (vb_q > bf) begin
          vb_d = bf;
        end
        if (item_q.func == FUNC_PUT) begin
          state_d = ST_BYTE;
        end else if (item_q.func == FUNC_SCROLL) begin
          state_d = ST_SCROLL;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_SCROLL: begin
        if (item_q.scroll_delta != '0) begin
          vis_s = vb_s + $signed({{(SW-10){item_q.scroll_delta[9]}}, item_q.scroll_delta});
          if (vis_s < 0) begin
            vis_s = '0;
          end else if (vis_s > bf_s) begin
            vis_s = bf_s;
          end
          vb_d = PW'(vis_s);
        end
        state_d = ST_FIN;
      end

      // Byte decode by escape state.
      ST_BYTE: begin
        state_d = ST_FIN;
        case (esc_q)
          ESC_SEEN: begin
            if (ch == CH_LBRK) begin
              esc_d  = ESC_CSI;
              plen_d = '0;
            end else begin
              esc_d = ESC_TEXT;
            end
          end
          ESC_CSI: begin
            if (ch >= FIN_LO && ch <= FIN_HI) begin
              esc_d   = ESC_TEXT;
              pos_d   = '0;
              state_d = ST_SCAN;
            end else if (plen_q < PBW'(PARAM_BYTES)) begin
              pb_we  = 1'b1;
              plen_d = plen_q + 1'b1;
            end
          end
          default: begin
            esc_d = ESC_TEXT;
            if (ch == CH_ESC) begin
              esc_d = ESC_SEEN;
            end else if (ch == CH_LF) begin
              col_d   = '0;
              lf_d    = 1'b1;
              state_d = ST_NL;
            end else if (ch == CH_BS) begin
              state_d = ST_BS;
            end else if (ch != CH_CR && ch >= CH_SPACE) begin
              state_d = ST_GROW;
            end
          end
        endcase
      end

      // Next line, growing the ring when the cursor passes its end.
      ST_NL: begin
        do_append = (nl_t >= held_q);
        cl_d      = (nl_t >= nl_h) ? PW'(nl_h - 1'b1) : PW'(nl_t);
        state_d   = lf_q ? ST_WIN : ST_FIN;
      end

      // Keep the cursor inside the bottom window after a line feed, when the view is at the bottom.
      ST_WIN: begin
        if (vb_q == '0) begin
          if (cl_q < bf) begin
            cl_d = bf;
          end else if (LW'(cl_q - bf) >= LW'(rows)) begin
            cl_d = PW'(LW'(bf) + LW'(rows) - 1'b1);
          end
        end
        state_d = ST_FIN;
      end

      ST_BS: begin
        if (col_q != '0) begin
          col_d = col_q - 1'b1;
        end else if (cl_q != '0) begin
          cl_d  = cl_q - 1'b1;
          col_d = CIW'(cols - 1'b1);
        end
        state_d = ST_BSW;
      end

      // Blank the cell under the cursor; a line never written is blank already.
      ST_BSW: begin
        if (LW'(cl_q) < held_q && valid_q[cur_phys]) begin
          we = 1'b1;
        end
        state_d = ST_FIN;
      end

      // Append lines up to the cursor, one a cycle.
      ST_GROW: begin
        if (LW'(cl_q) >= held_q && held_q < LW'(S)) begin
          do_append = 1'b1;
        end else begin
          if (LW'(cl_q) >= held_q) begin
            cl_d = PW'(held_q - 1'b1);
          end
          state_d = ST_PUT;
        end
      end

      ST_PUT: begin
        if (valid_q[cur_phys]) begin
          we      = 1'b1;
          wdata   = {attr_q, ch};
          state_d = ST_ADV;
        end else begin
          k_d      = '0;
          sw_put_d = 1'b1;
          state_d  = ST_SWEEP;
        end
      end

      // Row sweep: blanks a fresh line around a printed cell, or erases to end.
      ST_SWEEP: begin
        we    = 1'b1;
        waddr = addr_of(cur_phys, CIW'(k_q));
        if (sw_put_q && k_q == CNW'(col_q)) begin
          wdata = {attr_q, ch};
        end
        k_d = k_q + 1'b1;
        if (k_q == k_end) begin
          if (sw_put_q) begin
            valid_d[cur_phys] = 1'b1;
            state_d           = ST_ADV;
          end else begin
            state_d = ST_FIN;
          end
        end
      end

      ST_ADV: begin
        if (col_inc >= cols) begin
          col_d   = '0;
          lf_d    = 1'b0;
          state_d = ST_NL;
        end else begin
          col_d   = CIW'(col_inc);
          state_d = ST_FIN;
        end
      end

      // Parameter length ends at the first zero byte.
      ST_SCAN: begin
        if (pos_q < plen_q && pb_byte != 8'd0) begin
          pos_d = pos_q + 1'b1;
        end else begin
          peff_d  = pos_q;
          state_d = ST_CSI;
        end
      end

      ST_CSI: begin
        state_d = ST_FIN;
        pos_d   = '0;
        num_d   = '0;
        r_d     = NUM_W'(1);
        c_d     = NUM_W'(1);
        case (ch)
          FIN_J: begin
            if (first_b == CH_2) begin
              valid_d = '0;
              ring_d  = '0;
              held_d  = LW'(rows);
              vb_d    = '0;
              attr_d  = 1'b0;
              cl_d    = '0;
              col_d   = '0;
            end
          end
          FIN_M: begin
            attr_d = (first_b == CH_7);
          end
          FIN_K: begin
            if (LW'(cl_q) < held_q && valid_q[cur_phys]) begin
              k_d      = (first_b == CH_2) ? '0 : CNW'(col_q);
              sw_put_d = 1'b0;
              state_d  = ST_SWEEP;
            end
          end
          FIN_H, FIN_F: begin
            phase_d = PH_ROW;
            state_d = (peff_q != '0) ? ST_NUM : ST_APPLY;
          end
          FIN_A, FIN_B, FIN_C, FIN_D: begin
            phase_d = PH_CNT;
            state_d = (peff_q != '0) ? ST_NUM : ST_APPLY;
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end

      // One decimal digit a cycle, saturating.
      ST_NUM: begin
        if (pos_q < peff_q && is_digit(pb_byte)) begin
          num_d = (prod > 20'(NUM_MAX)) ? NUM_MAX : NUM_W'(prod);
          pos_d = pos_q + 1'b1;
        end else begin
          case (phase_q)
            PH_ROW: begin
              r_d     = num_q;
              state_d = ST_SKIP;
            end
            PH_COL: begin
              c_d     = num_q;
              state_d = ST_APPLY;
            end
            default: begin
              r_d     = num_q;
              state_d = ST_APPLY;
            end
          endcase
        end
      end

      ST_SKIP: begin
        if (pos_q < peff_q && pb_byte != CH_SEMI) begin
          pos_d = pos_q + 1'b1;
        end else if (pos_q < peff_q) begin
          pos_d   = pos_q + 1'b1;
          num_d   = '0;
          phase_d = PH_COL;
          state_d = ST_NUM;
        end else begin
          state_d = ST_APPLY;
        end
      end

      // Cursor moves.
      ST_APPLY: begin
        state_d = ST_FIN;
        nn      = (r_q == '0) ? NUM_W'(1) : r_q;
        n_s     = $signed(SW'(nn));
        case (ch)
          FIN_H, FIN_F: begin
            rr = (r_q == '0) ? NUM_W'(1) : r_q;
            if (rr > NUM_W'(rows)) begin
              rr = NUM_W'(rows);
            end
            cc = (c_q == '0) ? NUM_W'(1) : c_q;
            if (cc > NUM_W'(cols)) begin
              cc = NUM_W'(cols);
            end
            cl_d  = PW'(LW'(bf) + LW'(rr) - 1'b1);
            col_d = CIW'(cc - 1'b1);
          end
          FIN_A: begin
            vis_s = cl_s - bf_s - n_s;
            if (vis_s < 0) begin
              vis_s = '0;
            end
            cl_d = PW'(bf_s + vis_s);
          end
          FIN_B: begin
            vis_s = cl_s - bf_s + n_s;
            if (vis_s >= rows_s) begin
              vis_s = rows_s - 1;
            end
            cl_d = PW'(bf_s + vis_s);
          end
          FIN_C: begin
            csum = (NUM_W+1)'(col_q) + (NUM_W+1)'(nn);
            if (csum >= (NUM_W+1)'(cols)) begin
              col_d = CIW'(cols - 1'b1);
            end else begin
              col_d = CIW'(csum);
            end
          end
          FIN_D: begin
            col_d = (NUM_W'(col_q) > nn) ? CIW'(NUM_W'(col_q) - nn) : '0;
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end

      ST_FIN: begin
        if (vb_q > bf) begin
          vb_d = bf;
        end
        state_d = ST_RDA;
      end

      // Cell read for func 2; rows past the held lines read blank.
      ST_RDA: begin
        rd_blank_d = 1'b1;
        if (item_q.func == FUNC_READ) begin
          if ({3'b0, item_q.read_row} < 9'(rows) && {2'b0, item_q.read_col} < 9'(cols) &&
              sr < (LW+1)'(held_q) && valid_q[sr_phys]) begin
            re         = 1'b1;
            raddr      = addr_of(sr_phys, CIW'(item_q.read_col));
            rd_blank_d = 1'b0;
          end
        end
        state_d = ST_OUT;
      end

      ST_OUT: begin
        res_valid_o = 1'b1;
        if (item_q.func == FUNC_READ) begin
          res_o.cell_char = rd_blank_q ? CH_SPACE : rdata[7:0];
          res_o.cell_attr = rd_blank_q ? 1'b0 : rdata[8];
        end
        vis_s = cl_s - bf_s;
        if (vis_s >= 0 && vis_s < rows_s) begin
          res_o.cursor_view_row = 6'(vis_s);
          res_o.cursor_visible  = (vb_q == '0);
        end
        res_o.cursor_column = 7'(col_q);
        res_o.view_offset   = 8'(vb_q);
        res_o.lines_held    = 9'(held_q);
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Append one blank line: grow the ring, or drop the oldest line when full.
    if (do_append) begin
      if (held_q < LW'(S)) begin
        valid_d[phys_of(ring_q, (LW+1)'(held_q))] = 1'b0;
        held_d = held_q + 1'b1;
      end else begin
        valid_d[ring_q] = 1'b0;
        ring_d = (ring_q == PW'(S - 1)) ? '0 : ring_q + 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ring_q     <= '0;
      held_q     <= LW'(1);
      vb_q       <= '0;
      cl_q       <= '0;
      col_q      <= '0;
      esc_q      <= ESC_TEXT;
      plen_q     <= '0;
      attr_q     <= 1'b0;
      valid_q    <= '0;
      lf_q       <= 1'b0;
      sw_put_q   <= 1'b0;
      rd_blank_q <= 1'b1;
      phase_q    <= PH_ROW;
    end else begin
      state_q    <= state_d;
      ring_q     <= ring_d;
      held_q     <= held_d;
      vb_q       <= vb_d;
      cl_q       <= cl_d;
      col_q      <= col_d;
      esc_q      <= esc_d;
      plen_q     <= plen_d;
      attr_q     <= attr_d;
      valid_q    <= valid_d;
      lf_q       <= lf_d;
      sw_put_q   <= sw_put_d;
      rd_blank_q <= rd_blank_d;
      phase_q    <= phase_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pos_q  <= pos_d;
    peff_q <= peff_d;
    num_q  <= num_d;
    r_q    <= r_d;
    c_q    <= c_d;
    k_q    <= k_d;
    if (pb_we) begin
      pbuf_q[plen_q[PBI-1:0]] <= ch;
    end
  end

  att_ram #(
    .WIDTH (CELL_W),
    .DEPTH (S * MAX_COLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ----- rtl/ansi_text_terminal_scrollback.sv -----
// Text terminal with a scrollback ring: register port, stream ports, result register.
// Depends on att_pkg and att_core.
// One item at a time. A printed byte that lands on a line not yet written adds a row sweep
// over all MAX_COLS cells, erase-in-line adds a sweep to the end of the line, and a final
// byte adds parameter scanning of one byte a cycle.
// The single cell RAM port and the sequencer set this pace.
// Reset clears all control state and every line's valid flag, so the store reads blank at once.
module ansi_text_terminal_scrollback import att_pkg::*; #(
  parameter int unsigned MAX_COLS         = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS         = DEF_MAX_ROWS,
  parameter int unsigned SCROLLBACK_LINES = DEF_SCROLLBACK_LINES,
  parameter int unsigned PARAM_BYTES      = DEF_PARAM_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], scroll_delta[17:8], read_row[23:18], read_col[30:24], zero[31]
  input  logic [31:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cell_char[7:0], cell_attr[8], cursor_view_row[14:9], cursor_column[21:15],
  // cursor_visible[22], view_offset[30:23], lines_held[39:31]
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  cols_q;
  logic [6:0]  rows_q;
  logic        out_valid_q;
  att_result_t out_q;
  att_item_t   item;
  att_result_t res;
  logic        res_valid;
  logic        res_ready;
  reg_e        reg_sel;

  // Register file.
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign prdata  = (reg_sel == REG_ROW_COUNT) ? {25'b0, rows_q} : {24'b0, cols_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_COLUMN_COUNT: cols_q <= pwdata[7:0];
        REG_ROW_COUNT:    rows_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Input beat unpacking.
  assign item = '{func:         s_axis_tuser,
                  read_col:     s_axis_tdata[30:24],
                  read_row:     s_axis_tdata[23:18],
                  scroll_delta: s_axis_tdata[17:8],
                  char_code:    s_axis_tdata[7:0]};

  att_core #(
    .MAX_COLS         (MAX_COLS),
    .MAX_ROWS         (MAX_ROWS),
    .SCROLLBACK_LINES (SCROLLBACK_LINES),
    .PARAM_BYTES      (PARAM_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cols_cfg_i  (cols_q),
    .rows_cfg_i  (rows_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register decouples the result from the next item.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // The sequencer takes one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  // A visible cursor needs the view at the bottom.
  a_cursor_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.cursor_visible |-> res.view_offset == 8'd0)
    else $error("cursor visible while scrolled back");

  // A pending result keeps the block from taking input.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("ready while a result is pending");

endmodule

// ----- tb/ansi_text_terminal_scrollback_tb.sv -----
// Testbench for the scrollback text terminal: stream stimulus, register writes and checking.
// Holds its own model of the terminal in a scoreboard class; depends on att_pkg and the RTL.
`timescale 1ns / 100ps

module ansi_text_terminal_scrollback_tb;
  import att_pkg::*;

  localparam int unsigned LINE_CELLS  = 128;
  localparam int unsigned RING_LINES  = 256;
  localparam int unsigned ROW_CAP     = 64;
  localparam int unsigned PARAM_CAP   = 31;
  localparam int unsigned STORE_CELLS = LINE_CELLS * RING_LINES;
  localparam int unsigned STALL_LIMIT = 50000;
  localparam logic [1:0]  FUNC_NONE   = 2'd3;

  // Terminal model and the queue of results it predicts.
  class att_scoreboard;
    byte unsigned screen_chars[STORE_CELLS];
    bit           screen_rev[STORE_CELLS];
    byte unsigned csi_bytes[PARAM_CAP];
    int           col_reg, row_reg;
    int           ring_top, held, view_back, cur_line, cur_col, csi_len, pen_rev;
    esc_e         parse_state;
    att_result_t  want_q[$];
    int           errors;

    function new();
      for (int i = 0; i < STORE_CELLS; i++) begin
        screen_chars[i] = CH_SPACE;
        screen_rev[i]   = 1'b0;
      end
      col_reg = COLS_RESET;
      row_reg = ROWS_RESET;
      ring_top = 0; held = 1; view_back = 0; cur_line = 0; cur_col = 0;
      csi_len = 0; pen_rev = 0; parse_state = ESC_TEXT; errors = 0;
    endfunction

    function void write_reg(reg_e idx, int value);
      if (idx == REG_COLUMN_COUNT) col_reg = value & 8'hFF;
      else row_reg = value & 7'h7F;
    endfunction

    function int cols_used();
      if (col_reg < 1) return 1;
      if (col_reg > LINE_CELLS) return LINE_CELLS;
      return col_reg;
    endfunction

    function int rows_used();
      if (row_reg < 1) return 1;
      if (row_reg > ROW_CAP) return ROW_CAP;
      return row_reg;
    endfunction

    function int cell_index(int line, int col);
      return ((ring_top + line) % RING_LINES) * LINE_CELLS + (col % LINE_CELLS);
    endfunction

    function void blank_line(int line);
      int base;
      base = cell_index(line, 0);
      for (int i = 0; i < LINE_CELLS; i++) begin
        screen_chars[base + i] = CH_SPACE;
        screen_rev[base + i]   = 1'b0;
      end
    endfunction

    function void add_line();
      if (held < RING_LINES) begin
        blank_line(held);
        held++;
      end else begin
        ring_top = (ring_top + 1) % RING_LINES;
        blank_line(held - 1);
      end
    endfunction

    function int window_top();
      return held > rows_used() ? held - rows_used() : 0;
    endfunction

    function void clamp_view();
      if (view_back > window_top()) view_back = window_top();
    endfunction

    function void clamp_cursor_line();
      if (held == 0) held = 1;
      if (cur_line >= held) cur_line = held - 1;
    endfunction

    // Decimal parameter, saturating at the largest 16-bit value.
    function int parse_number(int len, inout int pos);
      int n;
      n = 0;
      while (pos < len && csi_bytes[pos] >= CH_0 && csi_bytes[pos] <= CH_9) begin
        n = n * 10 + (csi_bytes[pos] - CH_0);
        if (n > NUM_MAX) n = NUM_MAX;
        pos++;
      end
      return n;
    endfunction

    function void run_csi(int fin);
      int plen, pos, n, top, rows, cols, first, r, c, vis;
      plen = 0; pos = 0;
      top = window_top(); rows = rows_used(); cols = cols_used();
      while (plen < csi_len && plen < PARAM_CAP && csi_bytes[plen] != 0) plen++;
      first = plen > 0 ? csi_bytes[0] : 0;
      if (fin == FIN_J) begin
        // Full clear, then the window is filled with blank lines.
        if (first == CH_2) begin
          for (int i = 0; i < STORE_CELLS; i++) begin
            screen_chars[i] = CH_SPACE;
            screen_rev[i]   = 1'b0;
          end
          ring_top = 0; held = 0; view_back = 0; pen_rev = 0;
          for (int i = 0; i < rows; i++) add_line();
          cur_line = 0; cur_col = 0;
        end
      end else if (fin == FIN_H || fin == FIN_F) begin
        r = 1; c = 1;
        if (plen > 0) begin
          r = parse_number(plen, pos);
          while (pos < plen && csi_bytes[pos] != CH_SEMI) pos++;
          if (pos < plen) begin
            pos++;
            c = parse_number(plen, pos);
          end
        end
        if (r < 1) r = 1;
        if (c < 1) c = 1;
        if (r > rows) r = rows;
        if (c > cols) c = cols;
        cur_line = top + r - 1;
        cur_col  = c - 1;
      end else if (fin == FIN_M) begin
        pen_rev = (first == CH_7);
      end else if (fin == FIN_K) begin
        if (cur_line < held) begin
          for (int k = (first == CH_2) ? 0 : cur_col; k < cols; k++) begin
            screen_chars[cell_index(cur_line, k)] = CH_SPACE;
            screen_rev[cell_index(cur_line, k)]   = 1'b0;
          end
        end
      end else if (fin >= FIN_A && fin <= FIN_D) begin
        n = plen > 0 ? parse_number(plen, pos) : 1;
        if (n < 1) n = 1;
        if (fin == FIN_A) begin
          vis = cur_line - top - n;
          if (vis < 0) vis = 0;
          cur_line = top + vis;
        end else if (fin == FIN_B) begin
          vis = cur_line - top + n;
          if (vis >= rows) vis = rows - 1;
          cur_line = top + vis;
        end else if (fin == FIN_C) begin
          cur_col += n;
          if (cur_col >= cols) cur_col = cols - 1;
        end else begin
          cur_col = cur_col > n ? cur_col - n : 0;
        end
      end
    endfunction

    function void put_byte(int c);
      int cols, rows, top;
      cols = cols_used(); rows = rows_used();
      if (parse_state == ESC_SEEN) begin
        if (c == CH_LBRK) begin
          parse_state = ESC_CSI;
          csi_len = 0;
        end else begin
          parse_state = ESC_TEXT;
        end
        return;
      end
      if (parse_state == ESC_CSI) begin
        if (c >= FIN_LO && c <= FIN_HI) begin
          run_csi(c);
          parse_state = ESC_TEXT;
        end else if (csi_len < PARAM_CAP) begin
          csi_bytes[csi_len] = c;
          csi_len++;
        end
        return;
      end
      if (c == CH_ESC) begin
        parse_state = ESC_SEEN;
        return;
      end
      if (c == CH_CR) return;
      if (c == CH_LF) begin
        cur_col = 0;
        cur_line++;
        if (cur_line >= held) add_line();
        clamp_cursor_line();
        if (view_back == 0) begin
          top = window_top();
          if (cur_line < top) cur_line = top;
          if (cur_line - top >= rows) cur_line = top + rows - 1;
        end
        return;
      end
      if (c == CH_BS) begin
        if (cur_col > 0) cur_col--;
        else if (cur_line > 0) begin
          cur_line--;
          cur_col = cols - 1;
        end
        if (cur_line < held) begin
          screen_chars[cell_index(cur_line, cur_col)] = CH_SPACE;
          screen_rev[cell_index(cur_line, cur_col)]   = 1'b0;
        end
        return;
      end
      if (c < 32) return;
      // Printable byte, with wrap at the end of the line.
      while (cur_line >= held && held < RING_LINES) add_line();
      clamp_cursor_line();
      screen_chars[cell_index(cur_line, cur_col)] = c;
      screen_rev[cell_index(cur_line, cur_col)]   = pen_rev[0];
      cur_col++;
      if (cur_col >= cols) begin
        cur_col = 0;
        cur_line++;
        if (cur_line >= held) add_line();
        clamp_cursor_line();
      end
    endfunction

    // Applies one accepted input beat and queues the result it must produce.
    function void note_item(logic [1:0] func, logic [31:0] data);
      att_result_t want;
      int rows, top, src, rr, cc, vis, v;
      if (cur_col >= cols_used()) cur_col = cols_used() - 1;
      clamp_view();
      if (func == FUNC_PUT) put_byte(data[7:0]);
      else if (func == FUNC_SCROLL) begin
        v = $signed(data[17:8]);
        if (v != 0) begin
          v = view_back + v;
          if (v < 0) v = 0;
          if (v > window_top()) v = window_top();
          view_back = v;
        end
      end
      clamp_view();
      rows = rows_used(); top = window_top();
      want = '0;
      if (func == FUNC_READ) begin
        rr = data[23:18]; cc = data[30:24];
        src = top - view_back + rr;
        want.cell_char = CH_SPACE;
        if (rr < rows && cc < cols_used() && src < held) begin
          want.cell_char = screen_chars[cell_index(src, cc)];
          want.cell_attr = screen_rev[cell_index(src, cc)];
        end
      end
      vis = cur_line - top;
      if (vis >= 0 && vis < rows) begin
        want.cursor_view_row = vis;
        want.cursor_visible  = (view_back == 0);
      end
      want.cursor_column = cur_col;
      want.view_offset   = view_back;
      want.lines_held    = held;
      want_q.push_back(want);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(att_result_t got);
      att_result_t want;
      if (want_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = want_q.pop_front();
      compare_field("cell_char", want.cell_char, got.cell_char);
      compare_field("cell_attr", want.cell_attr, got.cell_attr);
      compare_field("cursor_view_row", want.cursor_view_row, got.cursor_view_row);
      compare_field("cursor_column", want.cursor_column, got.cursor_column);
      compare_field("cursor_visible", want.cursor_visible, got.cursor_visible);
      compare_field("view_offset", want.view_offset, got.view_offset);
      compare_field("lines_held", want.lines_held, got.lines_held);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  att_scoreboard term_sb = new();
  bit            no_gaps = 1'b0;
  int            stall_cycles = 0;

  ansi_text_terminal_scrollback i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check each beat, stall at random, and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) term_sb.check_result(att_result_t'(m_axis_tdata));
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else stall_cycles <= stall_cycles + 1;
    end
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 33);
  end

  // One input beat; tvalid stays high into the next beat unless a gap is taken.
  task automatic send_beat(logic [1:0] func, logic [7:0] ch, int delta, int row, int col);
    logic [9:0]  d10;
    logic [31:0] data;
    d10 = delta;
    data = {1'b0, 7'(col), 6'(row), d10, ch};
    if (!no_gaps && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    term_sb.note_item(func, data);
  endtask

  task automatic put(int ch);
    send_beat(FUNC_PUT, ch, $urandom_range(512) - 256, $urandom_range(63), $urandom_range(127));
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic read_cell(int row, int col);
    send_beat(FUNC_READ, $urandom_range(255), $urandom_range(512) - 256, row, col);
  endtask

  task automatic scroll(int delta);
    send_beat(FUNC_SCROLL, $urandom_range(255), delta, $urandom_range(63), $urandom_range(127));
  endtask

  // Stop sending and wait until every expected beat has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (term_sb.want_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e idx, int value);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    term_sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(int cols, int rows);
    drain();
    reg_write(REG_COLUMN_COUNT, cols);
    reg_write(REG_ROW_COUNT, rows);
    @(posedge clk_i);
  endtask

  // A well-formed control sequence with random parameters, sometimes overlong or odd.
  task automatic send_csi();
    byte unsigned finals[9];
    int len, pick;
    finals = '{FIN_J, FIN_H, FIN_F, FIN_M, FIN_K, FIN_A, FIN_B, FIN_C, FIN_D};
    put(CH_ESC);
    put(CH_LBRK);
    len = ($urandom_range(9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (i == 0 && pick < 30) put($urandom_range(1) ? CH_2 : CH_7);
      else if (pick < 70) put($urandom_range(CH_0, CH_9));
      else if (pick < 85) put(CH_SEMI);
      else if (pick < 92) put($urandom_range(0, FIN_LO - 1));
      else put($urandom_range(FIN_HI + 1, 255));
    end
    if ($urandom_range(9) == 0) put($urandom_range(FIN_LO, FIN_HI));
    else put(finals[$urandom_range(8)]);
  endtask

  task automatic random_items(int count);
    int pick, sent;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        put($urandom_range(32, 255));
        sent++;
      end else if (pick < 45) begin
        put(CH_LF);
        sent++;
      end else if (pick < 50) begin
        put(CH_BS);
        sent++;
      end else if (pick < 53) begin
        put($urandom_range(1) ? CH_CR : $urandom_range(0, 31));
        sent++;
      end else if (pick < 70) begin
        send_csi();
        sent += 4;
      end else if (pick < 73) begin
        // Escape and a random byte; a left bracket here opens a control sequence.
        put(CH_ESC);
        put($urandom_range(255));
        sent += 2;
      end else if (pick < 83) begin
        scroll($urandom_range(3) == 0 ? $urandom_range(512) - 256 : $urandom_range(16) - 8);
        sent++;
      end else if (pick < 97) begin
        read_cell($urandom_range(term_sb.rows_used() + 1 < 63 ? term_sb.rows_used() + 1 : 63),
                  $urandom_range(term_sb.cols_used() + 1 < 127 ? term_sb.cols_used() + 1 : 127));
        sent++;
      end else begin
        send_beat(FUNC_NONE, $urandom_range(255), $urandom_range(512) - 256,
                  $urandom_range(63), $urandom_range(127));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks at the reset geometry.
    set_geometry(80, 24);
    read_cell(0, 0);
    put_text("A");
    put(CH_ESC);
    put_text("[7mZ");
    put(CH_ESC);
    put_text("[m");
    read_cell(0, 1);
    put(CH_CR);
    put(CH_BS);
    put(CH_LF);
    put(CH_ESC);
    put_text("[2J");
    put(CH_ESC);
    put_text("[5;99H");
    put(CH_ESC);
    put_text("[K");
    read_cell(63, 127);
    scroll(256);
    scroll(-256);
    send_beat(FUNC_NONE, 8'hFF, 255, 63, 127);

    // Random traffic over several geometries, extremes and out-of-range values included.
    set_geometry(1, 1);
    random_items(60);
    set_geometry(128, 64);
    random_items(60);
    drain();
    random_items(20);
    set_geometry(0, 0);
    random_items(50);
    set_geometry(255, 127);
    no_gaps = 1'b1;
    random_items(50);
    no_gaps = 1'b0;
    set_geometry(20, 6);
    random_items(80);

    // One-column lines fill the whole ring quickly, so it rolls over.
    set_geometry(1, 64);
    for (int i = 0; i < 270; i++) put($urandom_range(32, 255));
    scroll(256);
    for (int i = 0; i < 6; i++) read_cell($urandom_range(63), 0);
    put(CH_LF);
    scroll(-256);
    random_items(40);
    set_geometry(40, 12);
    random_items(80);

    drain();
    if (term_sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
